// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define RDSBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// A trigger in a cycle implies the property in the next.
`define RDSBF_ASSERT_NEXT(label, trig, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
    else $error(msg);

`endif

// ----- rtl/rdsbf_pkg.sv -----
// ----------------------------------------------------------------------------
// rdsbf_pkg
// Types, constants and helpers for the RDS bit FIFO and biphase encoder.
// ----------------------------------------------------------------------------
package rdsbf_pkg;

  localparam int DefaultFifoDepth = 2048;
  localparam int MaxPushBits      = 26;
  localparam int CountW           = 5;
  localparam int FillW            = 12;
  localparam int LfsrW            = 16;

  localparam logic [LfsrW-1:0] LfsrSeed = 16'hACE1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // Classified request; push bits are left-aligned, first bit at the top.
  typedef struct packed {
    logic                   func;
    logic [MaxPushBits-1:0] bits;
    logic [CountW-1:0]      count;
  } cmd_t;

  typedef struct packed {
    logic             accepted;
    logic             symbol_valid;
    logic             line_symbol;
    logic             underrun;
    logic             want_more;
    logic [FillW-1:0] fill_level;
  } result_t;

  // Fibonacci LFSR, taps 16,14,13,11, shifting right.
  function automatic logic [LfsrW-1:0] lfsr_next(input logic [LfsrW-1:0] s);
    logic fb;
    fb = s[0] ^ s[2] ^ s[3] ^ s[5];
    return {fb, s[LfsrW-1:1]};
  endfunction

endpackage

// ----- rtl/rdsbf_ram.sv -----
// ----------------------------------------------------------------------------
// rdsbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rdsbf_ram
  import rdsbf_pkg::*;
#(
  parameter int WIDTH = 1,
  parameter int DEPTH = DefaultFifoDepth
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/rdsbf_front.sv -----
// ----------------------------------------------------------------------------
// rdsbf_front
// Accepts requests, clamps and aligns push bits, and queues them two deep.
// ----------------------------------------------------------------------------
module rdsbf_front
  import rdsbf_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [MaxPushBits-1:0] in_data_bits,
  input  logic [CountW-1:0]      in_bit_count,
  output logic                   cmd_valid,
  output cmd_t                   cmd,
  input  logic                   cmd_pop
);

  localparam int QDepth = 2;

  cmd_t              q_mem_r [QDepth];
  logic [1:0]        q_cnt_r, q_cnt_nxt;
  logic              wr_sel_r, rd_sel_r;
  logic              push;
  logic [CountW-1:0] cnt_c;
  cmd_t              cmd_in;

  assign in_stall  = (q_cnt_r == 2'(QDepth));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (q_cnt_r != 2'd0);
  assign cmd       = q_mem_r[rd_sel_r];

  always_comb begin
    cnt_c       = (in_bit_count > CountW'(MaxPushBits)) ? CountW'(MaxPushBits) : in_bit_count;
    cmd_in      = '0;
    cmd_in.func = in_func;
    unique case (in_func)
      FUNC_PUSH: begin
        cmd_in.count = cnt_c;
        // left-align so the first bit to send sits at the top
        cmd_in.bits  = in_data_bits << (CountW'(MaxPushBits) - cnt_c);
      end
      FUNC_TICK: begin
        cmd_in.count = '0;
      end
    endcase
  end

  always_comb begin
    case ({push, cmd_pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r  <= '0;
      wr_sel_r <= 1'b0;
      rd_sel_r <= 1'b0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (push) begin
        wr_sel_r <= ~wr_sel_r;
      end
      if (cmd_pop) begin
        rd_sel_r <= ~rd_sel_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_sel_r] <= cmd_in;
    end
  end

endmodule

// ----- rtl/rdsbf_back.sv -----
// ----------------------------------------------------------------------------
// rdsbf_back
// Executes queued requests: bit-serial store writes, ticks with differential
// biphase encoding and LFSR filler, and the result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdsbf_back
  import rdsbf_pkg::*;
#(
  parameter int FIFO_DEPTH = DefaultFifoDepth
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  cmd_t    cmd,
  output logic    cmd_pop,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_res
);

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [CW:0]   DepthW   = (CW+1)'(FIFO_DEPTH);
  localparam logic [AW-1:0] LastAddr = AW'(FIFO_DEPTH - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [AW-1:0]          wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]          rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]          used_r, used_nxt;
  logic                   phase_r, phase_nxt;
  logic                   last_r, last_nxt;
  logic [LfsrW-1:0]       lfsr_r, lfsr_nxt;
  logic [MaxPushBits-1:0] shift_r, shift_nxt;
  logic [CountW-1:0]      cnt_r, cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_res_r, out_res_nxt;

  logic    slot_free;
  logic    load;
  result_t res;
  logic    fits;
  logic    ram_we, ram_re, ram_rdata;

  rdsbf_ram #(
    .WIDTH(1),
    .DEPTH(FIFO_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr_r),
    .wdata(shift_r[MaxPushBits-1]),
    .re   (ram_re),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign slot_free = !out_valid_r || !out_stall;
  assign cmd_pop   = (state_r == ST_IDLE) && cmd_valid && slot_free;
  assign fits      = ((CW+1)'(used_r) + (CW+1)'(cmd.count) + (CW+1)'(1)) < DepthW;

  always_comb begin
    state_nxt  = state_r;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    used_nxt   = used_r;
    phase_nxt  = phase_r;
    last_nxt   = last_r;
    lfsr_nxt   = lfsr_r;
    shift_nxt  = shift_r;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    load       = 1'b0;
    res        = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (cmd_pop) begin
          unique case (cmd.func)
            FUNC_PUSH: begin
              res.fill_level = FillW'(used_r);
              if (fits && cmd.count != '0) begin
                shift_nxt = cmd.bits;
                cnt_nxt   = cmd.count;
                state_nxt = ST_WRITE;
              end else begin
                load         = 1'b1;
                res.accepted = fits;
              end
            end
            FUNC_TICK: begin
              phase_nxt        = ~phase_r;
              res.symbol_valid = 1'b1;
              res.fill_level   = FillW'(used_r);
              res.want_more    = ({used_r, 1'b0} < DepthW);
              if (!phase_r) begin
                if (used_r != '0) begin
                  // wait for the registered store read in ST_READ
                  ram_re    = 1'b1;
                  state_nxt = ST_READ;
                end else begin
                  lfsr_nxt        = lfsr_next(lfsr_r);
                  last_nxt        = lfsr_r[0] ^ last_r;
                  res.line_symbol = lfsr_r[0] ^ last_r;
                  res.underrun    = 1'b1;
                  load            = 1'b1;
                end
              end else begin
                res.line_symbol = ~last_r;
                load            = 1'b1;
              end
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we     = 1'b1;
        shift_nxt  = shift_r << 1;
        wr_ptr_nxt = (wr_ptr_r == LastAddr) ? '0 : wr_ptr_r + AW'(1);
        used_nxt   = used_r + CW'(1);
        cnt_nxt    = cnt_r - CountW'(1);
        if (cnt_r == CountW'(1)) begin
          load           = 1'b1;
          res.accepted   = 1'b1;
          res.fill_level = FillW'(used_nxt);
          state_nxt      = ST_IDLE;
        end
      end
      ST_READ: begin
        rd_ptr_nxt       = (rd_ptr_r == LastAddr) ? '0 : rd_ptr_r + AW'(1);
        used_nxt         = used_r - CW'(1);
        last_nxt         = ram_rdata ^ last_r;
        load             = 1'b1;
        res.symbol_valid = 1'b1;
        res.line_symbol  = ram_rdata ^ last_r;
        res.want_more    = ({used_nxt, 1'b0} < DepthW);
        res.fill_level   = FillW'(used_nxt);
        state_nxt        = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // hold the result until taken
    out_res_nxt = out_res_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      used_r      <= '0;
      phase_r     <= 1'b0;
      last_r      <= 1'b0;
      lfsr_r      <= LfsrSeed;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      used_r      <= used_nxt;
      phase_r     <= phase_nxt;
      last_r      <= last_nxt;
      lfsr_r      <= lfsr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r   <= shift_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  `RDSBF_ASSERT(a_used_bound, used_r < CW'(FIFO_DEPTH), "fill count reached store depth")
  `RDSBF_ASSERT(a_write_count, (state_r == ST_WRITE) |-> (cnt_r != '0), "write with no bits left")
  `RDSBF_ASSERT(a_read_nonempty, (state_r == ST_READ) |-> (used_r != '0), "read of empty store")
  `RDSBF_ASSERT(a_no_overwrite, load |-> slot_free, "result register overwritten")
  `RDSBF_ASSERT_NEXT(a_read_done, state_r == ST_READ, out_valid_r && state_r == ST_IDLE, "read did not complete")

endmodule

// ----- rtl/rds_bit_fifo_differential_biphase.sv -----
// The front queue registers each request before it hands it over to the back end. A tick
// result passes through ST_READ first when the tick reads the bit store. A push writes its
// n bits one after another in ST_WRITE; a refused or empty push writes nothing. Hand-over
// waits while ST_WRITE or ST_READ is busy or the result register holds a stalled result.
// Reset: synchronous, active low; clears pointers, fill count, phase, last symbol and
// loads the LFSR seed. The bit store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// rds_bit_fifo_differential_biphase
// RDS bit FIFO with differential encoder and mirrored biphase symbol output.
// ----------------------------------------------------------------------------
module rds_bit_fifo_differential_biphase
  import rdsbf_pkg::*;
#(
  parameter int FIFO_DEPTH = DefaultFifoDepth
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_func,
  input  logic [MaxPushBits-1:0] in_data_bits,
  input  logic [CountW-1:0]      in_bit_count,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_accepted,
  output logic                   out_symbol_valid,
  output logic                   out_line_symbol,
  output logic                   out_underrun,
  output logic                   out_want_more,
  output logic [FillW-1:0]       out_fill_level
);

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t out_res;

  rdsbf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_data_bits(in_data_bits),
    .in_bit_count(in_bit_count),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop)
  );

  rdsbf_back #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

  assign out_accepted     = out_res.accepted;
  assign out_symbol_valid = out_res.symbol_valid;
  assign out_line_symbol  = out_res.line_symbol;
  assign out_underrun     = out_res.underrun;
  assign out_want_more    = out_res.want_more;
  assign out_fill_level   = out_res.fill_level;

endmodule
